[design/dct_block_threshold_sharpen_defines.svh]
// Assertion macros shared by the checker of the block.
`ifndef DCT_BLOCK_THRESHOLD_SHARPEN_DEFINES_SVH
`define DCT_BLOCK_THRESHOLD_SHARPEN_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define DBTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define DBTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/dbts_pkg.sv]
// Types, constants and transform table shared by the block's modules.
`timescale 1ns / 1ps
`default_nettype none

package dbts_pkg;

    localparam int ADDR_W  = 6;
    localparam int PIX_W   = 8;
    localparam int THR_W   = 11;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 35;
    localparam int CNT_W   = 9;

    localparam logic [1:0] PASS_FROW = 2'd0;
    localparam logic [1:0] PASS_FCOL = 2'd1;
    localparam logic [1:0] PASS_IROW = 2'd2;
    localparam logic [1:0] PASS_ICOL = 2'd3;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_REF_MAX   = 1'b1;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_RUN,
        ST_WAIT
    } back_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [PIX_W-1:0]  pixel;
        logic              choice;
        logic              last;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  pass;
        logic [5:0]  o;
        logic [2:0]  k;
    } tag_t;

    localparam logic signed [COEF_W-1:0] HALF_COS [32] = '{
        16'sd16384, 16'sd16069, 16'sd15137, 16'sd13623,
        16'sd11585, 16'sd9102, 16'sd6270, 16'sd3196,
        16'sd0, -16'sd3196, -16'sd6270, -16'sd9102,
        -16'sd11585, -16'sd13623, -16'sd15137, -16'sd16069,
        -16'sd16384, -16'sd16069, -16'sd15137, -16'sd13623,
        -16'sd11585, -16'sd9102, -16'sd6270, -16'sd3196,
        16'sd0, 16'sd3196, 16'sd6270, 16'sd9102,
        16'sd11585, 16'sd13623, 16'sd15137, 16'sd16069
    };

    // DCT basis value for frequency u at sample x, Q15.
    function automatic logic signed [COEF_W-1:0] basis(input logic [2:0] u,
                                                       input logic [2:0] x);
        logic [4:0] odd;
        logic [4:0] ph;
        odd = {1'b0, x, 1'b1};
        ph  = odd * {2'b00, u};
        if (u == 3'd0)
            return 16'sd11585;
        return HALF_COS[ph];
    endfunction

endpackage

`default_nettype wire

[design/dbts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dbts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/dbts_front.sv]
// Input side: accepts pixel transactions and tags them with block position.
`timescale 1ns / 1ps
`default_nettype none

module dbts_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [dbts_pkg::PIX_W-1:0]    pixel_in,
    input  wire logic                          random_bit,
    input  wire logic                          queue_full,
    output logic                               push_valid,
    output dbts_pkg::item_t                    push_item
);

    logic [dbts_pkg::ADDR_W-1:0] fill_reg;
    logic [dbts_pkg::ADDR_W-1:0] fill_next;
    logic                        accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign fill_next = fill_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        push_valid       = accept;
        push_item.idx    = fill_reg;
        push_item.pixel  = pixel_in;
        push_item.choice = random_bit;
        push_item.last   = (fill_reg == {dbts_pkg::ADDR_W{1'b1}});
    end

endmodule

`default_nettype wire

[design/dbts_queue.sv]
// Short register queue between the input side and the transform engine.
`timescale 1ns / 1ps
`default_nettype none

module dbts_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    input  wire dbts_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output dbts_pkg::item_t      pop_item,
    output logic                 nonempty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dbts_pkg::item_t slots [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_next;
    logic          do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign do_pop   = pop && nonempty;
    assign pop_item = slots[rd_reg];
    assign wr_next  = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign rd_next  = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slots[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_reg <= wr_next;
            end
            if (do_pop)
            begin
                rd_reg <= rd_next;
            end
            if (push_valid && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !push_valid)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[design/dbts_back.sv]
// Transform engine: stores a block, runs four MAC passes and emits pixels.
`timescale 1ns / 1ps
`default_nettype none

module dbts_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dbts_pkg::item_t               pop_item,
    input  wire logic                          nonempty,
    output logic                               pop,
    input  wire logic [dbts_pkg::THR_W-1:0]    threshold,
    input  wire logic [dbts_pkg::PIX_W-1:0]    reference_max,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [dbts_pkg::PIX_W-1:0]         pixel_out,
    output logic                               last_of_block
);

    dbts_pkg::back_state_t state_reg;
    dbts_pkg::back_state_t state_next;
    logic [1:0]                   pass_reg;
    logic [1:0]                   pass_next;
    logic [dbts_pkg::CNT_W-1:0]   cnt_reg;
    logic [dbts_pkg::CNT_W-1:0]   cnt_next;

    dbts_pkg::tag_t t1_reg;
    dbts_pkg::tag_t t2_reg;
    dbts_pkg::tag_t t3_reg;
    dbts_pkg::tag_t t4_reg;

    logic signed [dbts_pkg::COEF_W-1:0] op_reg;
    logic signed [dbts_pkg::COEF_W-1:0] coef_reg;
    logic signed [dbts_pkg::PROD_W-1:0] prod_reg;
    logic signed [dbts_pkg::ACC_W-1:0]  acc_reg;
    logic signed [dbts_pkg::ACC_W-1:0]  acc_next;
    logic signed [dbts_pkg::ACC_W-1:0]  sum_reg;

    logic                        out_valid_reg;
    logic [dbts_pkg::PIX_W-1:0]  pix_reg;
    logic                        last_reg;

    logic [2:0] ia;
    logic [2:0] ib;
    logic [2:0] ik;
    logic       issue;
    logic       pipe_empty;

    logic                         blk_we;
    logic [dbts_pkg::ADDR_W-1:0]  blk_waddr;
    logic [15:0]                  blk_wdata;
    logic [dbts_pkg::ADDR_W-1:0]  blk_raddr;
    logic [15:0]                  blk_rdata;
    logic                         trn_we;
    logic [dbts_pkg::ADDR_W-1:0]  trn_raddr;
    logic [15:0]                  trn_rdata;
    logic                         chc_rdata;

    logic signed [15:0] s1_data;
    logic signed [15:0] s1_op;
    logic signed [15:0] s1_coef;
    logic [16:0]        s1_mag;
    logic [15:0]        s1_t;

    logic               s4_neg;
    logic [34:0]        s4_mag;
    logic [34:0]        s4_r;
    logic signed [15:0] s4_sat;
    logic [7:0]         s4_pix;

    assign ia = cnt_reg[8:6];
    assign ib = cnt_reg[5:3];
    assign ik = cnt_reg[2:0];

    assign pipe_empty = !t1_reg.valid && !t2_reg.valid && !t3_reg.valid && !t4_reg.valid;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            dbts_pkg::ST_FILL:
            begin
                if (nonempty && pop_item.last)
                begin
                    state_next = dbts_pkg::ST_RUN;
                    pass_next  = dbts_pkg::PASS_FROW;
                    cnt_next   = '0;
                end
            end
            dbts_pkg::ST_RUN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == {dbts_pkg::CNT_W{1'b1}})
                    begin
                        state_next = dbts_pkg::ST_WAIT;
                    end
                end
            end
            dbts_pkg::ST_WAIT:
            begin
                if (pipe_empty)
                begin
                    if (pass_reg == dbts_pkg::PASS_ICOL)
                    begin
                        state_next = dbts_pkg::ST_FILL;
                    end
                    else
                    begin
                        state_next = dbts_pkg::ST_RUN;
                        pass_next  = pass_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = dbts_pkg::ST_FILL;
            end
        endcase
    end

    // Sequencer outputs; the last pass starts a pixel only with a free output slot.
    always_comb
    begin
        pop   = 1'b0;
        issue = 1'b0;
        case (state_reg)
            dbts_pkg::ST_FILL:
            begin
                pop = nonempty;
            end
            dbts_pkg::ST_RUN:
            begin
                issue = (pass_reg != dbts_pkg::PASS_ICOL) || (ik != 3'd0) ||
                        (pipe_empty && !out_valid_reg);
            end
            default:
            begin
                pop   = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbts_pkg::ST_FILL;
            pass_reg  <= dbts_pkg::PASS_FROW;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign blk_raddr = {ia, ik};
    assign trn_raddr = {ik, ib};

    // Stage 1: pick operand, apply thresholding on the inverse row pass.
    always_comb
    begin
        case (t1_reg.pass)
            dbts_pkg::PASS_FROW: s1_data = $signed(blk_rdata);
            dbts_pkg::PASS_IROW: s1_data = $signed(blk_rdata);
            default:             s1_data = $signed(trn_rdata);
        endcase
        s1_t   = {2'b00, threshold, 3'b000};
        s1_mag = s1_data[15] ? 17'(-$signed({s1_data[15], s1_data})) : {1'b0, s1_data};
        s1_op  = s1_data;
        if ((t1_reg.pass == dbts_pkg::PASS_IROW) && (s1_mag < {1'b0, s1_t}))
        begin
            if (chc_rdata)
                s1_op = '0;
            else if (s1_data > 16'sd0)
                s1_op = $signed(s1_t);
            else
                s1_op = -$signed(s1_t);
        end
        case (t1_reg.pass)
            dbts_pkg::PASS_FROW: s1_coef = dbts_pkg::basis(t1_reg.o[2:0], t1_reg.k);
            dbts_pkg::PASS_FCOL: s1_coef = dbts_pkg::basis(t1_reg.o[5:3], t1_reg.k);
            dbts_pkg::PASS_IROW: s1_coef = dbts_pkg::basis(t1_reg.k, t1_reg.o[2:0]);
            default:             s1_coef = dbts_pkg::basis(t1_reg.k, t1_reg.o[5:3]);
        endcase
    end

    assign acc_next = (t3_reg.k == 3'd0) ? dbts_pkg::ACC_W'(prod_reg)
                                         : acc_reg + dbts_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else
        begin
            t1_reg.valid <= issue;
            t1_reg.pass  <= pass_reg;
            t1_reg.o     <= cnt_reg[8:3];
            t1_reg.k     <= ik;
            t2_reg       <= t1_reg;
            t3_reg       <= t2_reg;
            t4_reg.pass  <= t3_reg.pass;
            t4_reg.o     <= t3_reg.o;
            t4_reg.k     <= t3_reg.k;
            t4_reg.valid <= t3_reg.valid && (t3_reg.k == 3'd7);
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= s1_op;
        coef_reg <= s1_coef;
        prod_reg <= op_reg * coef_reg;
        if (t3_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        sum_reg <= acc_next;
    end

    // Stage 4: shift (rounding in all but the inverse column pass), saturation and clamp.
    always_comb
    begin
        s4_neg = sum_reg[34];
        s4_mag = s4_neg ? 35'(-sum_reg) : 35'(sum_reg);
        case (t4_reg.pass)
            dbts_pkg::PASS_FROW: s4_r = (s4_mag + 35'd2048) >> 12;
            dbts_pkg::PASS_FCOL: s4_r = (s4_mag + 35'd16384) >> 15;
            dbts_pkg::PASS_IROW: s4_r = (s4_mag + 35'd16384) >> 15;
            default:             s4_r = s4_mag >> 18;
        endcase
        if (!s4_neg)
            s4_sat = (s4_r > 35'd32767) ? 16'sd32767 : $signed(s4_r[15:0]);
        else
            s4_sat = (s4_r > 35'd32768) ? -16'sd32768 : -$signed(s4_r[15:0]);
        if (s4_neg)
            s4_pix = '0;
        else if (s4_r > {27'd0, reference_max})
            s4_pix = reference_max;
        else
            s4_pix = s4_r[7:0];
    end

    always_comb
    begin
        if (state_reg == dbts_pkg::ST_FILL)
        begin
            blk_we    = pop;
            blk_waddr = pop_item.idx;
            blk_wdata = {8'd0, pop_item.pixel};
        end
        else
        begin
            blk_we    = t4_reg.valid && (t4_reg.pass == dbts_pkg::PASS_FCOL);
            blk_waddr = t4_reg.o;
            blk_wdata = s4_sat;
        end
        trn_we = t4_reg.valid &&
                 ((t4_reg.pass == dbts_pkg::PASS_FROW) || (t4_reg.pass == dbts_pkg::PASS_IROW));
    end

    dbts_ram #(.WIDTH(16), .DEPTH(64)) u_blk (
        .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
        .raddr(blk_raddr), .rdata(blk_rdata)
    );

    dbts_ram #(.WIDTH(16), .DEPTH(64)) u_trn (
        .clk(clk), .we(trn_we), .waddr(t4_reg.o), .wdata(s4_sat),
        .raddr(trn_raddr), .rdata(trn_rdata)
    );

    dbts_ram #(.WIDTH(1), .DEPTH(64)) u_chc (
        .clk(clk), .we(pop && (state_reg == dbts_pkg::ST_FILL)), .waddr(pop_item.idx),
        .wdata(pop_item.choice), .raddr(blk_raddr), .rdata(chc_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (t4_reg.valid && (t4_reg.pass == dbts_pkg::PASS_ICOL))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t4_reg.valid && (t4_reg.pass == dbts_pkg::PASS_ICOL))
        begin
            pix_reg  <= s4_pix;
            last_reg <= (t4_reg.o == 6'd63);
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_out     = pix_reg;
    assign last_of_block = last_reg;

endmodule

`default_nettype wire

[design/dct_block_threshold_sharpen.sv]
// Top level of the 8x8 DCT coefficient thresholding block.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  input   | in        | in_valid / in_stall   | pixel_in, random_bit
//  output  | out       | out_valid / out_stall | pixel_out, last_of_block
//  config  | in        | APB, pready always 1  | threshold, reference_max
//
// Pixels are taken at one per cycle while the engine fills its store; during
// the transform the small queue fills and then the input stalls. One shared
// MAC unit runs three storing passes of 512 products, each followed by a
// pipeline drain, then a final pass of 512 products that starts each output
// pixel only once the pipeline is empty and the output register is free.
// Reset clears control state only; a stalled output holds its pixel and
// keeps the engine from starting the next one.
`timescale 1ns / 1ps
`default_nettype none

module dct_block_threshold_sharpen #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  pixel_in,
    input  wire logic        random_bit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       pixel_out,
    output logic             last_of_block,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [dbts_pkg::THR_W-1:0] threshold_reg;
    logic [dbts_pkg::PIX_W-1:0] ref_max_reg;
    logic                       cfg_write;

    logic            queue_full;
    logic            push_valid;
    dbts_pkg::item_t push_item;
    logic            pop;
    dbts_pkg::item_t pop_item;
    logic            nonempty;

    // Register file: threshold at byte address 0, reference_max at 4.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            ref_max_reg   <= 8'd255;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == dbts_pkg::REG_THRESHOLD)
                threshold_reg <= pwdata[dbts_pkg::THR_W-1:0];
            else
                ref_max_reg <= pwdata[dbts_pkg::PIX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == dbts_pkg::REG_REF_MAX) ? {24'd0, ref_max_reg}
                                                        : {21'd0, threshold_reg};

    // The front side numbers pixels within the block and marks the last one.
    dbts_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .pixel_in(pixel_in), .random_bit(random_bit), .queue_full(queue_full),
        .push_valid(push_valid), .push_item(push_item)
    );

    // The queue lets the input keep flowing while the engine fills its store.
    dbts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push_valid(push_valid), .push_item(push_item),
        .full(queue_full), .pop(pop), .pop_item(pop_item), .nonempty(nonempty)
    );

    // The engine runs the transform pair and drives the output register.
    dbts_back u_back (
        .clk(clk), .rst_n(rst_n), .pop_item(pop_item), .nonempty(nonempty), .pop(pop),
        .threshold(threshold_reg), .reference_max(ref_max_reg),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
        .last_of_block(last_of_block)
    );

endmodule

`default_nettype wire

[design/dbts_checker.sv]
// Port-level checker of the block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "dct_block_threshold_sharpen_defines.svh"

module dbts_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  pixel_out,
    input wire logic        last_of_block,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    `DBTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_out) && $stable(last_of_block), "stalled output transaction changed")
    `DBTS_ASSERT_NEXT(a_gap_after_block, out_valid && !out_stall && last_of_block, !out_valid, "output follows a finished block without new input")
    `DBTS_ASSERT_NEXT(a_thr_readback, psel && penable && pwrite && !paddr[2], paddr[2] || (prdata[10:0] == $past(pwdata[10:0])), "threshold readback mismatch")
    `DBTS_ASSERT_SAME(a_thr_upper_zero, psel && !paddr[2], prdata[31:11] == 21'd0, "threshold readback has upper bits set")

endmodule

bind dct_block_threshold_sharpen dbts_checker u_dbts_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .pixel_out(pixel_out), .last_of_block(last_of_block), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata)
);

`default_nettype wire
